// File: hdl/lsq_pkg.sv
// lsq_pkg: shared types, codes and helpers of the line strip quad expander
// used by lsq_norm and line_strip_to_quads; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lsq_pkg;

   // register index codes of the csr port
   localparam logic [2:0] CSR_CENTER_X   = 3'd0;
   localparam logic [2:0] CSR_CENTER_Y   = 3'd1;
   localparam logic [2:0] CSR_CENTER_Z   = 3'd2;
   localparam logic [2:0] CSR_HALF_WIDTH = 3'd3;
   localparam logic [2:0] CSR_OVERSHOOT  = 3'd4;

   // 0.1 in Q16.16
   localparam logic [30:0] DEFAULT_WIDTH = 31'd6554;

   localparam logic KIND_VERTEX   = 1'b0;
   localparam logic KIND_TRIANGLE = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_NRM_N = 7'b0000010,
      ST_NRM_T = 7'b0000100,
      ST_CROSS = 7'b0001000,
      ST_NRM_B = 7'b0010000,
      ST_SCALE = 7'b0100000,
      ST_OUT   = 7'b1000000
   } top_state_type;

   typedef enum logic [4:0] {
      NS_IDLE   = 5'b00001,
      NS_SHIFT  = 5'b00010,
      NS_SQUARE = 5'b00100,
      NS_ROOT   = 5'b01000,
      NS_DIVIDE = 5'b10000
   } norm_state_type;

   // handshake between the sequencer and the normalizer
   typedef struct packed {
      logic start;
   } norm_req_type;

   typedef struct packed {
      logic done;
   } norm_rsp_type;

   function automatic logic [31:0] sat32(input logic signed [34:0] v);
      logic [31:0] r;
      if (v > 35'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (v < -35'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // base +/- tangent offset +/- bitangent offset, saturated
   function automatic logic [31:0] vtx_coord(input logic signed [31:0] base,
                                             input logic signed [33:0] tofs,
                                             input logic signed [33:0] bofs,
                                             input logic fwd,
                                             input logic plus);
      logic signed [34:0] acc;
      acc = 35'(base);
      acc = fwd  ? acc + 35'(tofs) : acc - 35'(tofs);
      acc = plus ? acc + 35'(bofs) : acc - 35'(bofs);
      return sat32(acc);
   endfunction

endpackage

`default_nettype wire

// File: hdl/lsq_norm.sv
// lsq_norm: iterative vector normalizer giving a Q2.14 unit vector
// needs lsq_pkg; one squaring multiplier, a bit-serial root and a restoring divider
`timescale 1ns / 1ps
`default_nettype none

module lsq_norm (
   input  wire                    clock,
   input  wire                    reset,
   input  lsq_pkg::norm_req_type  req,
   input  wire  signed [33:0]     vec_x,
   input  wire  signed [33:0]     vec_y,
   input  wire  signed [33:0]     vec_z,
   output lsq_pkg::norm_rsp_type  rsp,
   output logic signed [15:0]     unit_x,
   output logic signed [15:0]     unit_y,
   output logic signed [15:0]     unit_z
);
   import lsq_pkg::*;

   norm_state_type state_ff, state_in;
   logic [33:0] mag_ff [3];
   logic [33:0] mag_in [3];
   logic [2:0]  neg_ff, neg_in;
   logic [33:0] m_ff, m_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [3:0]  step_ff, step_in;
   logic [50:0] sum_ff, sum_in;
   logic [47:0] prod_ff, prod_in;
   logic [50:0] rad_ff, rad_in;
   logic [51:0] root_ff, root_in;
   logic [50:0] bit_ff, bit_in;
   logic [24:0] len_ff, len_in;
   logic [38:0] rem_ff, rem_in;
   logic [39:0] den_ff, den_in;
   logic [15:0] quo_ff, quo_in;
   logic signed [15:0] unit_ff [3];
   logic signed [15:0] unit_in [3];
   logic done_ff, done_in;

   logic [33:0] in_mag [3];
   logic [2:0]  in_neg;
   logic [33:0] in_max;
   logic [23:0] sq_src;
   logic [51:0] trial;
   logic [51:0] root_step;
   logic [1:0]  load_idx;
   logic [24:0] load_len;
   logic [23:0] load_src;
   logic [38:0] load_rem;
   logic [39:0] load_den;
   logic [15:0] quo_next;
   logic [15:0] quo_clamp;

   assign in_neg = {vec_z[33], vec_y[33], vec_x[33]};
   assign in_mag[0] = vec_x[33] ? 34'(-vec_x) : 34'(vec_x);
   assign in_mag[1] = vec_y[33] ? 34'(-vec_y) : 34'(vec_y);
   assign in_mag[2] = vec_z[33] ? 34'(-vec_z) : 34'(vec_z);

   always_comb begin
      in_max = in_mag[0];
      if (in_mag[1] > in_max) begin
         in_max = in_mag[1];
      end
      if (in_mag[2] > in_max) begin
         in_max = in_mag[2];
      end
   end

   always_comb begin
      case (cnt_ff)
         2'd0:    sq_src = mag_ff[0][23:0];
         2'd1:    sq_src = mag_ff[1][23:0];
         default: sq_src = mag_ff[2][23:0];
      endcase
   end

   // one root step
   assign trial = root_ff + {1'b0, bit_ff};
   always_comb begin
      if ({1'b0, rad_ff} >= trial) begin
         root_step = (root_ff >> 1) + {1'b0, bit_ff};
      end else begin
         root_step = root_ff >> 1;
      end
   end

   // divider load: the first component right after the root, else the next one
   always_comb begin
      if (state_ff == NS_ROOT) begin
         load_idx = 2'd0;
         load_len = root_step[24:0];
      end else begin
         load_idx = cnt_ff + 2'd1;
         load_len = len_ff;
      end
      case (load_idx)
         2'd0:    load_src = mag_ff[0][23:0];
         2'd1:    load_src = mag_ff[1][23:0];
         default: load_src = mag_ff[2][23:0];
      endcase
      load_rem = {1'b0, load_src, 14'd0} + 39'(load_len >> 1);
      load_den = {load_len, 15'd0};
   end

   assign quo_next  = {quo_ff[14:0], {1'b0, rem_ff} >= den_ff};
   assign quo_clamp = (quo_next > 16'd16384) ? 16'd16384 : quo_next;

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      m_in     = m_ff;
      cnt_in   = cnt_ff;
      step_in  = step_ff;
      sum_in   = sum_ff;
      prod_in  = prod_ff;
      rad_in   = rad_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      len_in   = len_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      unit_in  = unit_ff;
      done_in  = 1'b0;
      case (state_ff)
         NS_IDLE: begin
            if (req.start) begin
               mag_in = in_mag;
               neg_in = in_neg;
               m_in   = in_max;
               if (in_max == 34'd0) begin
                  // zero vector stays zero
                  unit_in[0] = 16'sd0;
                  unit_in[1] = 16'sd0;
                  unit_in[2] = 16'sd0;
                  done_in    = 1'b1;
               end else begin
                  state_in = NS_SHIFT;
               end
            end
         end
         NS_SHIFT: begin
            if (m_ff >= 34'd16777216) begin
               mag_in[0] = mag_ff[0] >> 1;
               mag_in[1] = mag_ff[1] >> 1;
               mag_in[2] = mag_ff[2] >> 1;
               m_in      = m_ff >> 1;
            end else if (m_ff < 34'd8388608) begin
               mag_in[0] = mag_ff[0] << 1;
               mag_in[1] = mag_ff[1] << 1;
               mag_in[2] = mag_ff[2] << 1;
               m_in      = m_ff << 1;
            end else begin
               state_in = NS_SQUARE;
               cnt_in   = 2'd0;
               sum_in   = 51'd0;
            end
         end
         NS_SQUARE: begin
            prod_in = sq_src * sq_src;
            if (cnt_ff != 2'd0) begin
               sum_in = sum_ff + 51'(prod_ff);
            end
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = NS_ROOT;
               rad_in   = sum_ff + 51'(prod_ff);
               root_in  = 52'd0;
               bit_in   = 51'd1 << 50;
            end
         end
         NS_ROOT: begin
            if ({1'b0, rad_ff} >= trial) begin
               rad_in = rad_ff - trial[50:0];
            end
            root_in = root_step;
            bit_in  = bit_ff >> 2;
            if (bit_ff[0]) begin
               len_in   = root_step[24:0];
               rem_in   = load_rem;
               den_in   = load_den;
               quo_in   = 16'd0;
               step_in  = 4'd0;
               cnt_in   = 2'd0;
               state_in = NS_DIVIDE;
            end
         end
         NS_DIVIDE: begin
            if ({1'b0, rem_ff} >= den_ff) begin
               rem_in = rem_ff - den_ff[38:0];
            end
            den_in  = den_ff >> 1;
            quo_in  = quo_next;
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               unit_in[cnt_ff] = neg_ff[cnt_ff] ? -$signed(quo_clamp) : $signed(quo_clamp);
               if (cnt_ff == 2'd2) begin
                  done_in  = 1'b1;
                  state_in = NS_IDLE;
               end else begin
                  cnt_in  = cnt_ff + 2'd1;
                  rem_in  = load_rem;
                  den_in  = load_den;
                  quo_in  = 16'd0;
                  step_in = 4'd0;
               end
            end
         end
         default: begin
            state_in = NS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= NS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      m_ff    <= m_in;
      cnt_ff  <= cnt_in;
      step_ff <= step_in;
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      len_ff  <= len_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      unit_ff <= unit_in;
   end

   assign rsp.done = done_ff;
   assign unit_x   = unit_ff[0];
   assign unit_y   = unit_ff[1];
   assign unit_z   = unit_ff[2];

endmodule

`default_nettype wire

// File: hdl/line_strip_to_quads.sv
// line_strip_to_quads: expands 3d line strips into camera-facing quads
// needs lsq_pkg and lsq_norm
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  signals                       contents
// req       in         req_tvalid/tready/tdata/tuser  one strip point per beat
// rsp       out        rsp_tvalid/tready/tdata/tuser  vertex or triangle per beat
//                      rsp_tlast                      last beat of a segment
// csr       in         csr_we/addr/wdata              center, half width, overshoot
//
// a strip start or the first point after reset is only stored and gives no beats
// before its six beats, a segment point goes through lsq_norm for the normal and the
// tangent, the 17x32 multiplier for their cross product, lsq_norm for the bitangent
// and the multiplier again for the offset scaling; each normalization takes shift
// steps, squaring, root steps and a divide per component, and a zero vector skips them
// req_tready is high only while idle; rsp back pressure holds the current beat

module line_strip_to_quads #(
   parameter int INDEX_BITS = 24
) (
   input  wire          clock,
   input  wire          reset,
   // point_x, point_y, point_z from bit 0 up
   input  wire  [95:0]  req_tdata,
   // strip_start
   input  wire          req_tuser,
   input  wire          req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, index_a, index_b, index_c
   output logic [215:0] rsp_tdata,
   // kind
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   input  wire          csr_we,
   input  wire  [2:0]   csr_addr,
   input  wire  [31:0]  csr_wdata
);
   import lsq_pkg::*;

   top_state_type state_ff, state_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic [2:0]    out_k_ff, out_k_in;

   // configuration
   logic signed [31:0] center_x_ff, center_y_ff, center_z_ff;
   logic [30:0]        half_width_ff, overshoot_ff;

   // strip state
   logic signed [31:0] prev_ff [3];
   logic signed [31:0] prev_in [3];
   logic signed [31:0] pt_ff [3];
   logic signed [31:0] pt_in [3];
   logic               have_prev_ff, have_prev_in;
   logic [INDEX_BITS-1:0] next_index_ff, next_index_in;

   // per segment vectors
   logic signed [15:0] nrm_ff [3];
   logic signed [15:0] nrm_in [3];
   logic signed [15:0] tan_ff [3];
   logic signed [15:0] tan_in [3];
   logic signed [15:0] bin_ff [3];
   logic signed [15:0] bin_in [3];
   logic signed [31:0] cr_ff [3];
   logic signed [31:0] cr_in [3];
   // tangent offsets 0..2 then bitangent offsets 3..5
   logic signed [33:0] ofs_ff [6];
   logic signed [33:0] ofs_in [6];

   // shared multiplier
   logic signed [16:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [48:0] prod_ff, prod_in;
   logic               sgn_ff, sgn_in;
   logic [47:0]        rnd;
   logic signed [33:0] scaled;
   logic [15:0]        sc_u;
   logic               sc_neg;

   // normalizer hookup
   norm_req_type       nreq_ff, nreq_in;
   norm_rsp_type       nrsp;
   logic signed [33:0] nvec_x, nvec_y, nvec_z;
   logic signed [15:0] nunit_x, nunit_y, nunit_z;

   // output beat
   logic [INDEX_BITS-1:0] idx_full [4];
   logic [23:0]           idx [4];
   logic                  is_tri, fwd, plus;
   logic signed [31:0]    base [3];
   logic [31:0]           pos [3];
   logic [23:0]           ia, ib, ic;
   logic [15:0]           nx, ny, nz;
   logic [31:0]           px, py, pz;

   logic req_fire, rsp_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   lsq_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .req    (nreq_ff),
      .vec_x  (nvec_x),
      .vec_y  (nvec_y),
      .vec_z  (nvec_z),
      .rsp    (nrsp),
      .unit_x (nunit_x),
      .unit_y (nunit_y),
      .unit_z (nunit_z)
   );

   // normalizer operand follows the state
   always_comb begin
      case (state_ff)
         ST_NRM_N: begin
            nvec_x = 34'(prev_ff[0]) - 34'(center_x_ff);
            nvec_y = 34'(prev_ff[1]) - 34'(center_y_ff);
            nvec_z = 34'(prev_ff[2]) - 34'(center_z_ff);
         end
         ST_NRM_T: begin
            nvec_x = 34'(pt_ff[0]) - 34'(prev_ff[0]);
            nvec_y = 34'(pt_ff[1]) - 34'(prev_ff[1]);
            nvec_z = 34'(pt_ff[2]) - 34'(prev_ff[2]);
         end
         default: begin
            nvec_x = 34'(cr_ff[0]);
            nvec_y = 34'(cr_ff[1]);
            nvec_z = 34'(cr_ff[2]);
         end
      endcase
   end

   // scaling operand: tangent with overshoot, then bitangent with half width
   always_comb begin
      case (cnt_ff)
         3'd0:    sc_u = tan_ff[0];
         3'd1:    sc_u = tan_ff[1];
         3'd2:    sc_u = tan_ff[2];
         3'd3:    sc_u = bin_ff[0];
         3'd4:    sc_u = bin_ff[1];
         default: sc_u = bin_ff[2];
      endcase
      sc_neg = sc_u[15];
      if (sc_neg) begin
         sc_u = 16'(-$signed(sc_u));
      end
   end

   // multiplier operands
   always_comb begin
      mul_a = 17'sd0;
      mul_b = 32'sd0;
      if (state_ff == ST_CROSS) begin
         case (cnt_ff)
            3'd0: begin mul_a = 17'(nrm_ff[1]); mul_b = 32'(tan_ff[2]); end
            3'd1: begin mul_a = 17'(nrm_ff[2]); mul_b = 32'(tan_ff[1]); end
            3'd2: begin mul_a = 17'(nrm_ff[2]); mul_b = 32'(tan_ff[0]); end
            3'd3: begin mul_a = 17'(nrm_ff[0]); mul_b = 32'(tan_ff[2]); end
            3'd4: begin mul_a = 17'(nrm_ff[0]); mul_b = 32'(tan_ff[1]); end
            3'd5: begin mul_a = 17'(nrm_ff[1]); mul_b = 32'(tan_ff[0]); end
            default: begin mul_a = 17'sd0; mul_b = 32'sd0; end
         endcase
      end else if (state_ff == ST_SCALE) begin
         mul_a = $signed({1'b0, sc_u});
         mul_b = (cnt_ff < 3'd3) ? $signed({1'b0, overshoot_ff})
                                 : $signed({1'b0, half_width_ff});
      end
   end

   // rounded magnitude of the scaled offset, sign restored
   assign rnd    = prod_ff[47:0] + 48'd8192;
   assign scaled = sgn_ff ? -$signed({1'b0, rnd[46:14]}) : $signed({1'b0, rnd[46:14]});

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      out_k_in      = out_k_ff;
      prev_in       = prev_ff;
      pt_in         = pt_ff;
      have_prev_in  = have_prev_ff;
      next_index_in = next_index_ff;
      nrm_in        = nrm_ff;
      tan_in        = tan_ff;
      bin_in        = bin_ff;
      cr_in         = cr_ff;
      ofs_in        = ofs_ff;
      prod_in       = mul_a * mul_b;
      sgn_in        = sc_neg;
      nreq_in.start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser || !have_prev_ff) begin
                  // first point of a strip is only stored
                  if (req_tuser) begin
                     next_index_in = '0;
                  end
                  prev_in[0]   = req_tdata[31:0];
                  prev_in[1]   = req_tdata[63:32];
                  prev_in[2]   = req_tdata[95:64];
                  have_prev_in = 1'b1;
               end else begin
                  pt_in[0]      = req_tdata[31:0];
                  pt_in[1]      = req_tdata[63:32];
                  pt_in[2]      = req_tdata[95:64];
                  state_in      = ST_NRM_N;
                  nreq_in.start = 1'b1;
               end
            end
         end
         ST_NRM_N: begin
            if (nrsp.done) begin
               nrm_in[0]     = nunit_x;
               nrm_in[1]     = nunit_y;
               nrm_in[2]     = nunit_z;
               state_in      = ST_NRM_T;
               nreq_in.start = 1'b1;
            end
         end
         ST_NRM_T: begin
            if (nrsp.done) begin
               tan_in[0] = nunit_x;
               tan_in[1] = nunit_y;
               tan_in[2] = nunit_z;
               state_in  = ST_CROSS;
               cnt_in    = 3'd0;
            end
         end
         ST_CROSS: begin
            // product of step c is registered and taken up in step c+1
            case (cnt_ff)
               3'd1: cr_in[0] = 32'(prod_ff);
               3'd2: cr_in[0] = cr_ff[0] - 32'(prod_ff);
               3'd3: cr_in[1] = 32'(prod_ff);
               3'd4: cr_in[1] = cr_ff[1] - 32'(prod_ff);
               3'd5: cr_in[2] = 32'(prod_ff);
               3'd6: cr_in[2] = cr_ff[2] - 32'(prod_ff);
               default: cr_in = cr_ff;
            endcase
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd6) begin
               state_in      = ST_NRM_B;
               nreq_in.start = 1'b1;
            end
         end
         ST_NRM_B: begin
            if (nrsp.done) begin
               bin_in[0] = nunit_x;
               bin_in[1] = nunit_y;
               bin_in[2] = nunit_z;
               state_in  = ST_SCALE;
               cnt_in    = 3'd0;
            end
         end
         ST_SCALE: begin
            if (cnt_ff != 3'd0) begin
               ofs_in[cnt_ff - 3'd1] = scaled;
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd6) begin
               state_in = ST_OUT;
               out_k_in = 3'd0;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               out_k_in = out_k_ff + 3'd1;
               if (out_k_ff == 3'd5) begin
                  prev_in       = pt_ff;
                  next_index_in = next_index_ff + INDEX_BITS'(4);
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         have_prev_ff  <= 1'b0;
         next_index_ff <= '0;
         nreq_ff       <= '0;
         prev_ff       <= '{default: 32'sd0};
      end else begin
         state_ff      <= state_in;
         have_prev_ff  <= have_prev_in;
         next_index_ff <= next_index_in;
         nreq_ff       <= nreq_in;
         prev_ff       <= prev_in;
      end
      cnt_ff   <= cnt_in;
      out_k_ff <= out_k_in;
      pt_ff    <= pt_in;
      nrm_ff   <= nrm_in;
      tan_ff   <= tan_in;
      bin_ff   <= bin_in;
      cr_ff    <= cr_in;
      ofs_ff   <= ofs_in;
      prod_ff  <= prod_in;
      sgn_ff   <= sgn_in;
   end

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff   <= 32'sd0;
         center_y_ff   <= 32'sd0;
         center_z_ff   <= 32'sd0;
         half_width_ff <= DEFAULT_WIDTH;
         overshoot_ff  <= DEFAULT_WIDTH;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_CENTER_X:   center_x_ff   <= csr_wdata;
            CSR_CENTER_Y:   center_y_ff   <= csr_wdata;
            CSR_CENTER_Z:   center_z_ff   <= csr_wdata;
            CSR_HALF_WIDTH: half_width_ff <= csr_wdata[30:0];
            CSR_OVERSHOOT:  overshoot_ff  <= csr_wdata[30:0];
            default: begin
            end
         endcase
      end
   end

   // output beat assembly
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         idx_full[k] = next_index_ff + INDEX_BITS'(k);
         idx[k]      = 24'(idx_full[k]);
      end
   end

   assign is_tri = out_k_ff[2];
   assign fwd    = out_k_ff[1];
   assign plus   = !out_k_ff[0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         base[i] = fwd ? pt_ff[i] : prev_ff[i];
         pos[i]  = vtx_coord(base[i], ofs_ff[i], ofs_ff[i + 3], fwd, plus);
      end
   end

   always_comb begin
      if (is_tri) begin
         px = 32'd0;
         py = 32'd0;
         pz = 32'd0;
         nx = 16'd0;
         ny = 16'd0;
         nz = 16'd0;
         ia = idx[0];
         // first triangle s,s+1,s+3 then s,s+3,s+2
         ib = out_k_ff[0] ? idx[3] : idx[1];
         ic = out_k_ff[0] ? idx[2] : idx[3];
      end else begin
         px = pos[0];
         py = pos[1];
         pz = pos[2];
         nx = nrm_ff[0];
         ny = nrm_ff[1];
         nz = nrm_ff[2];
         ia = idx[out_k_ff[1:0]];
         ib = 24'd0;
         ic = 24'd0;
      end
   end

   assign rsp_tdata = {ic, ib, ia, nz, ny, nx, pz, py, px};
   assign rsp_tuser = is_tri ? KIND_TRIANGLE : KIND_VERTEX;
   assign rsp_tlast = (out_k_ff == 3'd5);

endmodule

`default_nettype wire

// File: bench/line_strip_to_quads_tb.sv
// line_strip_to_quads_tb: self-checking bench for the line strip quad expander
// predicts vertex and triangle beats per strip point; needs lsq_pkg and the rtl
`timescale 1ns / 1ps

module line_strip_to_quads_tb;
   import lsq_pkg::*;

   typedef struct packed {
      logic        kind;
      logic [31:0] px, py, pz;
      logic [15:0] nx, ny, nz;
      logic [23:0] ia, ib, ic;
      logic        last;
   } quad_beat_type;

   typedef struct packed {
      logic [31:0] x, y, z;
      logic        start;
   } strip_point_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic [95:0]   req_tdata = '0;
   logic          req_tuser = 1'b0;
   logic          req_tvalid = 1'b0;
   wire           req_tready;
   wire  [215:0]  rsp_tdata;
   wire           rsp_tuser, rsp_tlast, rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic          csr_we = 1'b0;
   logic [2:0]    csr_addr = '0;
   logic [31:0]   csr_wdata = '0;

   line_strip_to_quads dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic signed [31:0] m_cx, m_cy, m_cz, m_px, m_py, m_pz;
   logic [30:0]        m_hw, m_os;
   logic               m_have;
   logic [23:0]        m_next;

   strip_point_type pending_points[$];
   quad_beat_type   expected_beats[$];
   int           errors = 0, beats_seen = 0, points_sent = 0;
   bit           calm = 0;   // no idling on either side
   bit           req_fired = 0;
   int           hold_off = 0;

   task automatic report(input string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   task automatic stash_beat(input quad_beat_type e);
      expected_beats.insert(expected_beats.size(), e);
   endtask

   function automatic longint isqrt(input longint unsigned v);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // unit vector in q2.14; zero stays zero
   task automatic to_unit(input longint v[3], output int u[3]);
      longint unsigned mg[3], m, sum, len, q;
      bit neg[3];
      m = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mg[i] = neg[i] ? -v[i] : v[i];
         if (mg[i] > m) m = mg[i];
      end
      if (m == 0) begin
         u = '{0, 0, 0};
         return;
      end
      while (m >= (64'd1 << 24)) begin
         for (int i = 0; i < 3; i++) mg[i] >>= 1;
         m >>= 1;
      end
      while (m < (64'd1 << 23)) begin
         for (int i = 0; i < 3; i++) mg[i] <<= 1;
         m <<= 1;
      end
      for (int i = 0; i < 3; i++) sum += mg[i] * mg[i];
      len = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = (mg[i] * 16384 + len / 2) / len;
         if (q > 16384) q = 16384;
         u[i] = neg[i] ? -int'(q) : int'(q);
      end
   endtask

   function automatic longint scale_unit(input int u, input logic [30:0] k);
      longint unsigned mg, r;
      mg = (u < 0) ? -u : u;
      r = (mg * k + 8192) >> 14;
      return (u < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic logic [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   task automatic predict_segment(input strip_point_type p);
      longint cur[3], nxt[3], d[3], t[3], b[3], c;
      int nn[3], tt[3], bb[3];
      logic [23:0] idx[4];
      quad_beat_type e;
      if (p.start || !m_have) begin
         if (p.start) m_next = '0;
         m_px = p.x; m_py = p.y; m_pz = p.z;
         m_have = 1'b1;
         return;
      end
      cur = '{m_px, m_py, m_pz};
      nxt = '{signed'(p.x), signed'(p.y), signed'(p.z)};
      d = '{cur[0] - m_cx, cur[1] - m_cy, cur[2] - m_cz};
      to_unit(d, nn);
      for (int i = 0; i < 3; i++) d[i] = nxt[i] - cur[i];
      to_unit(d, tt);
      d[0] = longint'(nn[1]) * tt[2] - longint'(nn[2]) * tt[1];
      d[1] = longint'(nn[2]) * tt[0] - longint'(nn[0]) * tt[2];
      d[2] = longint'(nn[0]) * tt[1] - longint'(nn[1]) * tt[0];
      to_unit(d, bb);
      for (int i = 0; i < 3; i++) begin
         t[i] = scale_unit(tt[i], m_os);
         b[i] = scale_unit(bb[i], m_hw);
      end
      for (int k = 0; k < 4; k++) idx[k] = m_next + 24'(k);
      for (int k = 0; k < 4; k++) begin
         logic [31:0] pc[3];
         for (int i = 0; i < 3; i++) begin
            c = (k < 2) ? cur[i] - t[i] : nxt[i] + t[i];
            c = (k % 2 == 0) ? c + b[i] : c - b[i];
            pc[i] = clamp32(c);
         end
         e = '{KIND_VERTEX, pc[0], pc[1], pc[2], nn[0][15:0], nn[1][15:0],
               nn[2][15:0], idx[k], 24'd0, 24'd0, 1'b0};
         stash_beat(e);
      end
      stash_beat('{KIND_TRIANGLE, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0,
                   idx[0], idx[1], idx[3], 1'b0});
      stash_beat('{KIND_TRIANGLE, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0,
                   idx[0], idx[3], idx[2], 1'b1});
      m_next = m_next + 24'd4;
      m_px = p.x; m_py = p.y; m_pz = p.z;
   endtask

   // point driver: prediction happens on acceptance
   always @(posedge clock) begin
      req_fired = !reset && req_tvalid && req_tready;
      if (req_fired) begin
         predict_segment(pending_points.pop_front());
         points_sent++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fired) begin
         // hold the offered beat
      end else if (pending_points.size() > 0 &&
                   (calm || $urandom_range(99) >= 19)) begin
         req_tvalid <= 1'b1;
         req_tdata  <= {pending_points[0].z, pending_points[0].y, pending_points[0].x};
         req_tuser  <= pending_points[0].start;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // result sink: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && (calm || $urandom_range(99) >= 19);
      end
   end

   always @(posedge clock) begin
      quad_beat_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_seen++;
         got = '{rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                 rsp_tdata[111:96], rsp_tdata[127:112], rsp_tdata[143:128],
                 rsp_tdata[167:144], rsp_tdata[191:168], rsp_tdata[215:192], rsp_tlast};
         if (expected_beats.size() == 0) begin
            report($sformatf("unexpected beat %h", got));
         end else begin
            want = expected_beats.pop_front();
            if (got.kind != want.kind) report($sformatf("kind %0d exp %0d", got.kind, want.kind));
            if (got.px != want.px) report($sformatf("pos_x %h exp %h", got.px, want.px));
            if (got.py != want.py) report($sformatf("pos_y %h exp %h", got.py, want.py));
            if (got.pz != want.pz) report($sformatf("pos_z %h exp %h", got.pz, want.pz));
            if (got.nx != want.nx) report($sformatf("norm_x %h exp %h", got.nx, want.nx));
            if (got.ny != want.ny) report($sformatf("norm_y %h exp %h", got.ny, want.ny));
            if (got.nz != want.nz) report($sformatf("norm_z %h exp %h", got.nz, want.nz));
            if (got.ia != want.ia) report($sformatf("index_a %h exp %h", got.ia, want.ia));
            if (got.ib != want.ib) report($sformatf("index_b %h exp %h", got.ib, want.ib));
            if (got.ic != want.ic) report($sformatf("index_c %h exp %h", got.ic, want.ic));
            if (got.last != want.last) report($sformatf("last %0d exp %0d", got.last, want.last));
         end
      end
   end

   task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      case (addr)
         CSR_CENTER_X:   m_cx = value;
         CSR_CENTER_Y:   m_cy = value;
         CSR_CENTER_Z:   m_cz = value;
         CSR_HALF_WIDTH: m_hw = value[30:0];
         CSR_OVERSHOOT:  m_os = value[30:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // wait until all points went in and every beat came out, then let the block settle
   task automatic drain();
      while (pending_points.size() > 0 || req_tvalid || expected_beats.size() > 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic add_point(input logic [31:0] x, y, z, input logic s);
      pending_points.insert(pending_points.size(), strip_point_type'{x, y, z, s});
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom;                                  // full range
         1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         2: return 32'($signed($urandom_range(20)) - 10) <<< 16;
         default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
      endcase
   endfunction

   task automatic random_strips(input int n);
      logic [31:0] x, y, z;
      for (int i = 0; i < n; i++) begin
         // mostly continuing strips, sometimes a repeated point
         if ($urandom_range(9) == 0 && i > 0) begin
            add_point(x, y, z, 1'b0);
         end else begin
            x = rand_coord();
            y = rand_coord();
            z = rand_coord();
            add_point(x, y, z, $urandom_range(11) == 0);
         end
      end
   endtask

   initial begin
      m_cx = 0; m_cy = 0; m_cz = 0;
      m_hw = DEFAULT_WIDTH; m_os = DEFAULT_WIDTH;
      m_px = 0; m_py = 0; m_pz = 0;
      m_have = 1'b0; m_next = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: first point without start, defaults, zero vector cases, extremes
      add_point(32'h0001_0000, 0, 0, 1'b0);
      add_point(32'h0002_0000, 0, 0, 1'b0);       // normal parallel to tangent
      add_point(32'h0002_0000, 0, 0, 1'b0);       // repeated point
      add_point(32'h0002_0000, 32'h0001_0000, 0, 1'b0);
      add_point(0, 0, 0, 1'b0);
      add_point(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0); // from the centre
      add_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
      add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      add_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
      add_point(32'hffff_ffff, 32'h0000_0001, 32'hffff_fffe, 1'b0);
      add_point(32'h0000_0003, 32'hffff_fffd, 32'h0000_0001, 1'b0);
      drain();

      write_reg(CSR_CENTER_X, 32'h8000_0000);
      write_reg(CSR_CENTER_Y, 32'h7fff_ffff);
      write_reg(CSR_CENTER_Z, 32'h8000_0000);
      write_reg(CSR_HALF_WIDTH, 32'h7fff_ffff);
      write_reg(CSR_OVERSHOOT, 32'h7fff_ffff);
      add_point(32'h7fff_ffff, 0, 32'h7fff_ffff, 1'b1);
      add_point(32'h8000_0000, 32'h7fff_ffff, 0, 1'b0);
      add_point(32'h1234_5678, 32'h8765_4321, 32'h0, 1'b0);
      add_point(32'h0, 32'h0, 32'h0, 1'b0);
      drain();

      write_reg(CSR_HALF_WIDTH, 0);
      write_reg(CSR_OVERSHOOT, 0);
      add_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1);
      add_point(32'h0004_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
      add_point(32'h0004_0000, 32'h0005_0000, 32'hfff3_0000, 1'b0);
      drain();

      // random phases, each with its own register setting
      for (int phase = 0; phase < 5; phase++) begin
         write_reg(CSR_CENTER_X, rand_coord());
         write_reg(CSR_CENTER_Y, rand_coord());
         write_reg(CSR_CENTER_Z, rand_coord());
         write_reg(CSR_HALF_WIDTH, phase == 4 ? 32'h7fff_ffff : $urandom_range(1 << 20));
         write_reg(CSR_OVERSHOOT, phase == 3 ? 32'h0 : $urandom);
         calm = (phase == 2);
         if (phase == 1) begin
            // sink holds off while points keep coming
            random_strips(12);
            @(negedge clock);
            hold_off <= 3000;
            random_strips(38);
         end else begin
            random_strips(50);
         end
         drain();
      end

      $display("covered %0d strip points and %0d result beats over several register sets",
               points_sent, beats_seen);
      $display("including extreme coordinates, zero vectors, strip restarts and a long stall");
      if (errors == 0) begin
         $display("** line_strip_to_quads: PASSED **");
      end else begin
         $display("** line_strip_to_quads: FAILED **");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout at %0t", $time);
      $display("** line_strip_to_quads: FAILED **");
      $finish;
   end

endmodule
